// File: hdl/s2lab_pkg.sv
package s2lab_pkg;

   // Intermediates are unsigned Q1.30 with one bit of headroom above 1.0.
   localparam int QB    = 30;
   localparam int FIX_W = QB + 1;

   localparam logic [63:0] ONE_Q = 64'd1 << QB;

   // Width of one sRGB channel code; the all-ones code is full intensity.
   localparam int CHANNEL_BITS = 8;

   // Latency of each part of the pipeline, in register stages.
   localparam int DEG_LAT  = 1;
   localparam int MIX_LAT  = 1;
   localparam int DIV_LAT  = 3;
   localparam int LABF_LAT = 2 * FIX_W + 1;
   localparam int OUT_LAT  = 2;
   localparam int PIPE_LAT = DEG_LAT + MIX_LAT + DIV_LAT + LABF_LAT + OUT_LAT;

   // One pixel in and one L*a*b* result out.
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
      logic                    frame_end;
   } req_type;

   typedef struct packed {
      logic [14:0]        lightness;
      logic signed [15:0] green_red;
      logic signed [15:0] blue_yellow;
      logic               frame_end_out;
   } rsp_type;

endpackage

// File: hdl/s2lab_degamma.sv
module s2lab_degamma (
   input  logic                               clock,
   input  logic [s2lab_pkg::CHANNEL_BITS-1:0] code,
   output logic [s2lab_pkg::FIX_W-1:0]        linear
);
   import s2lab_pkg::*;

   localparam int          LUT_N   = 1 << CHANNEL_BITS;
   localparam logic [63:0] CH_MAX  = (64'd1 << CHANNEL_BITS) - 64'd1;
   localparam logic [63:0] LIN_DEN = 64'd1292 * CH_MAX;
   localparam logic [63:0] POW_DEN = 64'd1055 * CH_MAX;

   typedef logic [FIX_W-1:0] lut_type [LUT_N];

   // Truncating Q1.30 product.
   function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> QB;
   endfunction

   // Largest Q1.30 value whose truncated fifth power does not exceed u.
   function automatic logic [63:0] root5(input logic [63:0] u);
      logic [63:0] y;
      logic [63:0] c;
      logic [63:0] c2;
      logic [63:0] c4;
      y = 64'd0;
      for (int bit_i = QB; bit_i >= 0; bit_i--) begin
         c = y | (64'd1 << bit_i);
         if (c <= ONE_Q) begin
            c2 = mulq(c, c);
            c4 = mulq(c2, c2);
            if (mulq(c4, c) <= u) begin
               y = c;
            end
         end
      end
      return y;
   endfunction

   // Gamma decode of one channel code: linear segment or the 2.4 power law.
   function automatic logic [FIX_W-1:0] degamma(input logic [CHANNEL_BITS-1:0] code_c);
      logic [63:0] c;
      logic [63:0] t;
      logic [63:0] u;
      logic [63:0] r;
      c = 64'(code_c) & CH_MAX;
      if (64'd100000 * c <= 64'd4045 * CH_MAX) begin
         r = (((64'd100 * c) << QB) + LIN_DEN / 2) / LIN_DEN;
      end else begin
         t = (((64'd1000 * c + 64'd55 * CH_MAX) << QB) + POW_DEN / 2) / POW_DEN;
         u = mulq(t, t);
         r = mulq(u, root5(u));
      end
      return r[FIX_W-1:0];
   endfunction

   function automatic lut_type build_lut();
      lut_type lut;
      for (int i = 0; i < LUT_N; i++) begin
         lut[i] = degamma(CHANNEL_BITS'(i));
      end
      return lut;
   endfunction

   localparam lut_type LUT = build_lut();

   logic [FIX_W-1:0] linear_ff;

   // Registered table read.
   always_ff @(posedge clock) begin
      linear_ff <= LUT[code];
   end

   assign linear = linear_ff;

endmodule

// File: hdl/s2lab_cdiv.sv
module s2lab_cdiv #(
   parameter int      NUM_W   = 47,
   parameter longint  DIVISOR = 95047,
   parameter int      SHIFT   = 16
) (
   input  logic                        clock,
   input  logic [NUM_W-1:0]            num,
   output logic [s2lab_pkg::FIX_W-1:0] quot
);
   import s2lab_pkg::*;

   localparam int          HI_W     = NUM_W - SHIFT;
   localparam int          RECIP_SH = 31;
   localparam logic [63:0] RECIP    = (64'd1 << (SHIFT + RECIP_SH)) / DIVISOR;
   localparam int          EST_W    = FIX_W + 1;
   localparam logic [NUM_W-1:0] DIV_N  = NUM_W'(DIVISOR);
   localparam logic [NUM_W-1:0] DIV_N2 = NUM_W'(2 * DIVISOR);

   logic [HI_W+RECIP_SH-1:0] prod;
   logic [EST_W-1:0]         est1_in, est1_ff, est2_ff;
   logic [NUM_W-1:0]         num1_ff, rem2_in, rem2_ff;
   logic [FIX_W-1:0]         quot_in, quot_ff;

   // Reciprocal estimate from the top bits; it is low by at most two.
   assign prod    = (HI_W+RECIP_SH)'(num[NUM_W-1:SHIFT]) * (HI_W+RECIP_SH)'(RECIP[RECIP_SH-1:0]);
   assign est1_in = EST_W'(prod >> RECIP_SH);

   // Remainder of the estimate, then up to two correction steps.
   assign rem2_in = num1_ff - NUM_W'(est1_ff) * DIV_N;
   assign quot_in = FIX_W'(est2_ff + EST_W'(rem2_ff >= DIV_N) + EST_W'(rem2_ff >= DIV_N2));

   always_ff @(posedge clock) begin
      est1_ff <= est1_in;
      num1_ff <= num;
      est2_ff <= est1_ff;
      rem2_ff <= rem2_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

// File: hdl/s2lab_labf.sv
module s2lab_labf (
   input  logic                        clock,
   input  logic [s2lab_pkg::FIX_W-1:0] ratio,
   output logic [s2lab_pkg::FIX_W-1:0] fval
);
   import s2lab_pkg::*;

   localparam int          NB      = FIX_W;
   localparam logic [63:0] THR     = (64'd8856 << QB) / 64'd1000000;
   localparam logic [63:0] LIN_C   = (64'd7787 << 28) / 64'd1000;
   localparam logic [63:0] LIN_OFF = ((64'd16 << QB) + 64'd58) / 64'd116;
   localparam int          LV_W    = 24;
   localparam int          LN_W    = 37;

   logic [FIX_W-1:0] va_ff [NB];
   logic [FIX_W-1:0] ya_ff [NB];
   logic [FIX_W:0]   sqa_ff [NB];
   logic [FIX_W-1:0] lina_ff [NB];
   logic [FIX_W-1:0] vb_ff [NB];
   logic [FIX_W-1:0] yb_ff [NB];
   logic [FIX_W-1:0] linb_ff [NB];
   logic [LN_W-1:0]  linn_ff;
   logic [FIX_W-1:0] fval_ff;

   // Linear segment: 7.787 v rounded by a reciprocal estimate, fixed up in step two.
   logic [LV_W+FIX_W-1:0] lprod;
   logic [LN_W-1:0]       lnum_in;
   logic [LN_W-1:0]       lrem;
   logic [FIX_W-1:0]      lq;

   assign lprod   = (LV_W+FIX_W)'(ratio[LV_W-1:0]) * (LV_W+FIX_W)'(LIN_C[FIX_W-1:0])
                    + ((LV_W+FIX_W)'(1) << 27);
   assign lnum_in = LN_W'(ratio[LV_W-1:0]) * LN_W'(7787) + LN_W'(500);
   assign lrem    = linn_ff - LN_W'(lina_ff[0]) * LN_W'(1000);
   assign lq      = lina_ff[0] + FIX_W'(lrem >= LN_W'(1000));

   always_ff @(posedge clock) begin
      linn_ff <= lnum_in;
   end

   // Cube root, one result bit per two stages: square, then cube and compare.
   for (genvar k = 0; k < NB; k++) begin : g_bit
      localparam logic [FIX_W-1:0] BITM = FIX_W'(1) << (QB - k);

      logic [FIX_W-1:0]   v_src, y_src, lin_src, cand_a, cand_b;
      logic [2*FIX_W-1:0] sq_full;
      logic [2*FIX_W:0]   cube_full;
      logic [FIX_W+1:0]   cube;

      if (k == 0) begin : g_first
         assign v_src   = ratio;
         assign y_src   = '0;
         assign lin_src = FIX_W'(lprod >> 28);
      end else begin : g_next
         assign v_src   = vb_ff[k-1];
         assign y_src   = yb_ff[k-1];
         assign lin_src = linb_ff[k-1];
      end

      assign cand_a    = y_src | BITM;
      assign sq_full   = (2*FIX_W)'(cand_a) * (2*FIX_W)'(cand_a);
      assign cand_b    = ya_ff[k] | BITM;
      assign cube_full = (2*FIX_W+1)'(sqa_ff[k]) * (2*FIX_W+1)'(cand_b);
      assign cube      = cube_full[2*FIX_W:QB];

      always_ff @(posedge clock) begin
         va_ff[k]   <= v_src;
         ya_ff[k]   <= y_src;
         sqa_ff[k]  <= sq_full[2*FIX_W-1:QB];
         lina_ff[k] <= lin_src;
         vb_ff[k]   <= va_ff[k];
         yb_ff[k]   <= (cube <= (FIX_W+2)'(va_ff[k])) ? cand_b : ya_ff[k];
      end

      if (k == 0) begin : g_lin_first
         always_ff @(posedge clock) begin
            linb_ff[k] <= lq + LIN_OFF[FIX_W-1:0];
         end
      end else begin : g_lin_next
         always_ff @(posedge clock) begin
            linb_ff[k] <= lina_ff[k];
         end
      end
   end

   // Pick the cube root above the knee, the linear segment at or below it.
   always_ff @(posedge clock) begin
      fval_ff <= (vb_ff[NB-1] > THR[FIX_W-1:0]) ? yb_ff[NB-1] : linb_ff[NB-1];
   end

   assign fval = fval_ff;

endmodule

// File: hdl/srgb_to_cielab.sv
// sRGB to CIE L*a*b* (D65) converter.
// Throughput: one pixel per cycle; busy stays low and the result side cannot stall.
// The depth is set by the bit-serial cube root, two stages per result bit.
// Reset clears only the valid pipeline; no result strobe appears for pixels in flight.
module srgb_to_cielab #(
   parameter int OUT_FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  s2lab_pkg::req_type req,
   output logic               rsp_valid,
   output s2lab_pkg::rsp_type rsp
);
   import s2lab_pkg::*;

   localparam int SW     = 42;
   localparam int RND_SH = QB - OUT_FRAC_BITS;
   localparam int NX_W   = 47;
   localparam int NY_W   = 44;
   localparam int NZ_W   = 47;

   logic                accept;
   logic [PIPE_LAT-1:0] valid_pipe_ff;
   logic [PIPE_LAT-1:0] fe_pipe_ff;

   logic [FIX_W-1:0] lin_r, lin_g, lin_b;
   logic [NX_W-1:0]  nx_ff;
   logic [NY_W-1:0]  ny_ff;
   logic [NZ_W-1:0]  nz_ff;
   logic [FIX_W-1:0] rx, ry, rz;
   logic [FIX_W-1:0] fx, fy, fz;

   logic signed [SW-1:0] fx_s, fy_s, fz_s;
   logic signed [SW-1:0] lp_ff, ap_ff, bp_ff;
   logic signed [SW-1:0] lo_in, ao_in, bo_in;
   logic [14:0]          light_ff;
   logic signed [15:0]   ga_ff, bb_ff;

   // Scale to the output fraction, rounding halves away from zero, then clamp.
   function automatic logic signed [SW-1:0] to_out(input logic signed [SW-1:0] v,
                                                   input logic signed [SW-1:0] lo,
                                                   input logic signed [SW-1:0] hi);
      logic [SW-1:0]        mag;
      logic [SW-1:0]        r;
      logic signed [SW-1:0] s;
      mag = v[SW-1] ? SW'(-v) : SW'(v);
      r   = (mag + (SW'(1) << (RND_SH - 1))) >> RND_SH;
      s   = v[SW-1] ? -signed'(r) : signed'(r);
      if (s < lo) begin
         s = lo;
      end else if (s > hi) begin
         s = hi;
      end
      return s;
   endfunction

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Valid and frame-end flags ride alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pipe_ff <= '0;
      end else begin
         valid_pipe_ff <= {valid_pipe_ff[PIPE_LAT-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      fe_pipe_ff <= {fe_pipe_ff[PIPE_LAT-2:0], req.frame_end};
   end

   // Gamma decode, one table per channel.
   s2lab_degamma u_deg_r (.clock(clock), .code(req.red),   .linear(lin_r));
   s2lab_degamma u_deg_g (.clock(clock), .code(req.green), .linear(lin_g));
   s2lab_degamma u_deg_b (.clock(clock), .code(req.blue),  .linear(lin_b));

   // Matrix rows, pre-scaled for the white-point division and its rounding.
   always_ff @(posedge clock) begin
      nx_ff <= NX_W'(41240) * NX_W'(lin_r) + NX_W'(35760) * NX_W'(lin_g)
             + NX_W'(18050) * NX_W'(lin_b) + NX_W'(47523);
      ny_ff <= NY_W'(2126) * NY_W'(lin_r) + NY_W'(7152) * NY_W'(lin_g)
             + NY_W'(722) * NY_W'(lin_b) + NY_W'(5000);
      nz_ff <= NZ_W'(1930) * NZ_W'(lin_r) + NZ_W'(11920) * NZ_W'(lin_g)
             + NZ_W'(95050) * NZ_W'(lin_b) + NZ_W'(54441);
   end

   // Divide by the reference white.
   s2lab_cdiv #(.NUM_W(NX_W), .DIVISOR(95047),  .SHIFT(16))
      u_div_x (.clock(clock), .num(nx_ff), .quot(rx));
   s2lab_cdiv #(.NUM_W(NY_W), .DIVISOR(10000),  .SHIFT(13))
      u_div_y (.clock(clock), .num(ny_ff), .quot(ry));
   s2lab_cdiv #(.NUM_W(NZ_W), .DIVISOR(108883), .SHIFT(16))
      u_div_z (.clock(clock), .num(nz_ff), .quot(rz));

   // Cube root or linear segment per axis.
   s2lab_labf u_labf_x (.clock(clock), .ratio(rx), .fval(fx));
   s2lab_labf u_labf_y (.clock(clock), .ratio(ry), .fval(fy));
   s2lab_labf u_labf_z (.clock(clock), .ratio(rz), .fval(fz));

   assign fx_s = signed'(SW'(fx));
   assign fy_s = signed'(SW'(fy));
   assign fz_s = signed'(SW'(fz));

   // L, a and b as signed Q12.30 before scaling.
   always_ff @(posedge clock) begin
      lp_ff <= SW'(116) * fy_s - (signed'(SW'(16)) <<< QB);
      ap_ff <= SW'(500) * (fx_s - fy_s);
      bp_ff <= SW'(200) * (fy_s - fz_s);
   end

   assign lo_in = to_out(lp_ff, SW'(0), SW'(32767));
   assign ao_in = to_out(ap_ff, -SW'(32768), SW'(32767));
   assign bo_in = to_out(bp_ff, -SW'(32768), SW'(32767));

   always_ff @(posedge clock) begin
      light_ff <= lo_in[14:0];
      ga_ff    <= ao_in[15:0];
      bb_ff    <= bo_in[15:0];
   end

   assign rsp_valid         = valid_pipe_ff[PIPE_LAT-1];
   assign rsp.lightness     = light_ff;
   assign rsp.green_red     = ga_ff;
   assign rsp.blue_yellow   = bb_ff;
   assign rsp.frame_end_out = fe_pipe_ff[PIPE_LAT-1];

   // Every transfer produces a strobe at the end of the pipeline.
   a_start_to_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LAT rsp_valid)
      else $error("transfer produced no result");

   // No strobe appears without a matching transfer at the head of the pipeline.
   a_result_has_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_LAT))
      else $error("result without a transfer");

endmodule
